// ----- design/i2da_pkg.sv -----
// Shared constants and types for the integer to decimal ASCII formatter.
package i2da_pkg;

  localparam int DEFAULT_VALUE_BITS = 64;
  localparam int INPUT_BITS         = 64;
  localparam int CHAR_BITS          = 6;
  localparam int DIGIT_BITS         = 4;

  localparam logic [CHAR_BITS-1:0]  CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_BITS-1:0]  CHAR_MINUS = 6'd45;
  localparam logic [DIGIT_BITS-1:0] DIGIT_FIVE  = 4'd5;
  localparam logic [DIGIT_BITS-1:0] DIGIT_THREE = 4'd3;

  typedef struct packed {
    logic clear;
    logic convert;
    logic shift;
  } cell_ctl_t;

endpackage

// ----- design/i2da_cell.sv -----
// One decimal digit cell: shift-and-add-3 step, or digit hand-off to the next cell.
module i2da_cell
  import i2da_pkg::*;
(
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic                  carry_in,
  input  logic [DIGIT_BITS-1:0] digit_in,
  output logic [DIGIT_BITS-1:0] digit,
  output logic                  carry_out
);

  logic [DIGIT_BITS-1:0] adjusted;

  always_comb begin
    adjusted  = (digit >= DIGIT_FIVE) ? digit + DIGIT_THREE : digit;
    carry_out = adjusted[DIGIT_BITS-1];
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= '0;
    end else if (ctl.convert) begin
      digit <= {adjusted[DIGIT_BITS-2:0], carry_in};
    end else if (ctl.shift) begin
      digit <= digit_in;
    end
  end

endmodule

// ----- design/integer_to_decimal_ascii.sv -----
// Top level: formats a binary word as decimal ASCII text, one character per strobe.
//
// Input: an item (value, treat_as_signed) is taken at a rising edge with start
// high and busy low. Only the low VALUE_BITS bits of value and bit 0 of the flag
// count. A negative signed word is printed as '-' and its magnitude.
// Conversion: a row of NUM_DIGITS BCD cells runs shift-and-add-3, one input bit
// per cycle. Output: the cells then shift their digits up one place per cycle;
// leading zeros are dropped, the rest leave the top cell as characters. The
// sign goes out before the digits. Each character sits on character/last_char
// for one cycle with strobe high; last_char marks the final digit. The
// receiver cannot stall. Busy spans the bit-serial conversion through the cell
// row, the sign when negative and the digit shift-out; no new item is taken
// while busy. The final strobe may overlap the next accept.
// Reset: synchronous, clears the sequencer and the strobe; no item in flight.
module integer_to_decimal_ascii
  import i2da_pkg::*;
#(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [INPUT_BITS-1:0] value,
  input  logic                  treat_as_signed,
  output logic                  strobe,
  output logic [CHAR_BITS-1:0]  character,
  output logic                  last_char
);

  localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BCNT_BITS  = $clog2(VALUE_BITS + 1);
  localparam int DCNT_BITS  = $clog2(NUM_DIGITS + 1);

  typedef enum logic [1:0] {IDLE, CONV, SIGN, EMIT} state_t;

  state_t                 state;
  logic [VALUE_BITS-1:0]  mag;
  logic [BCNT_BITS-1:0]   bcnt;
  logic [DCNT_BITS-1:0]   dcnt;
  logic                   negative;
  logic                   lead_seen;

  logic [VALUE_BITS-1:0]  word;
  logic                   neg_in;
  logic [VALUE_BITS-1:0]  mag_load;
  cell_ctl_t              ctl;
  logic [DIGIT_BITS-1:0]  digit   [NUM_DIGITS];
  logic [DIGIT_BITS-1:0]  shift_in[NUM_DIGITS];
  logic                   carry   [NUM_DIGITS+1];
  logic [DIGIT_BITS-1:0]  top;
  logic                   skip;
  logic                   final_digit;

  always_comb begin
    word        = value[VALUE_BITS-1:0];
    neg_in      = treat_as_signed && word[VALUE_BITS-1];
    mag_load    = neg_in ? (~word + VALUE_BITS'(1)) : word;
    top         = digit[NUM_DIGITS-1];
    final_digit = (dcnt == DCNT_BITS'(1));
    skip        = (top == '0) && !final_digit && !lead_seen;
    ctl.clear   = (state == IDLE) && start;
    ctl.convert = (state == CONV);
    ctl.shift   = (state == EMIT) && !final_digit;
  end

  assign busy     = (state != IDLE);
  assign carry[0] = mag[VALUE_BITS-1];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign shift_in[i] = '0;
    end else begin : g_rest
      assign shift_in[i] = digit[i-1];
    end
    i2da_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .carry_in  (carry[i]),
      .digit_in  (shift_in[i]),
      .digit     (digit[i]),
      .carry_out (carry[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            mag      <= mag_load;
            negative <= neg_in;
            bcnt     <= BCNT_BITS'(VALUE_BITS);
            state    <= CONV;
          end
        end
        CONV: begin
          mag  <= {mag[VALUE_BITS-2:0], 1'b0};
          bcnt <= bcnt - BCNT_BITS'(1);
          if (bcnt == BCNT_BITS'(1)) begin
            dcnt      <= DCNT_BITS'(NUM_DIGITS);
            lead_seen <= 1'b0;
            state     <= negative ? SIGN : EMIT;
          end
        end
        SIGN: begin
          strobe    <= 1'b1;
          character <= CHAR_MINUS;
          last_char <= 1'b0;
          state     <= EMIT;
        end
        EMIT: begin
          if (!skip) begin
            strobe    <= 1'b1;
            character <= CHAR_ZERO + CHAR_BITS'(top);
            last_char <= final_digit;
            lead_seen <= 1'b1;
          end
          if (final_digit) begin
            state <= IDLE;
          end else begin
            dcnt <= dcnt - DCNT_BITS'(1);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ctl.convert |-> !carry[NUM_DIGITS])
    else $error("digit chain overflow during conversion");

  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !strobe))
    else $error("strobe right after an accepted item");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_char) |=> !strobe)
    else $error("character following the last one of an item");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (character == CHAR_MINUS)) |-> !last_char)
    else $error("sign marked as last character");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ((character == CHAR_MINUS) ||
                ((character >= CHAR_ZERO) && (character <= CHAR_ZERO + CHAR_BITS'(9)))))
    else $error("illegal character code");

endmodule

// ----- tb/sv/decimal_text_checker.sv -----
// Checker for the decimal ASCII formatter: predicts each item's text and compares every strobe.
`timescale 1ns / 100ps

module decimal_text_checker
  import i2da_pkg::*;
#(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [INPUT_BITS-1:0] value,
  input  logic                  treat_as_signed,
  input  logic                  strobe,
  input  logic [CHAR_BITS-1:0]  character,
  input  logic                  last_char,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [CHAR_BITS-1:0] symbol;
    logic                 final_mark;
  } text_char_t;

  localparam logic [INPUT_BITS-1:0] WORD_MASK = {INPUT_BITS{1'b1}} >> (INPUT_BITS - VALUE_BITS);
  localparam int MAX_DIGITS = 20;

  text_char_t expected_text[$];
  int         char_count;

  initial begin
    errors     = 0;
    pending    = 0;
    char_count = 0;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic void queue_decimal_text(input logic [INPUT_BITS-1:0] raw,
                                             input logic as_signed);
    logic [INPUT_BITS-1:0] word;
    logic [INPUT_BITS-1:0] magnitude;
    logic [3:0]            digits[MAX_DIGITS];
    logic                  negative;
    int                    ndigits;
    text_char_t            entry;
    word      = raw & WORD_MASK;
    negative  = as_signed && word[VALUE_BITS-1];
    magnitude = negative ? ((~word + 1'b1) & WORD_MASK) : word;
    ndigits   = 0;
    do begin
      digits[ndigits] = 4'(magnitude % 10);
      magnitude       = magnitude / 10;
      ndigits++;
    end while (magnitude != 0 && ndigits < MAX_DIGITS);
    if (negative) begin
      entry.symbol     = CHAR_MINUS;
      entry.final_mark = 1'b0;
      expected_text.push_back(entry);
    end
    for (int i = ndigits - 1; i >= 0; i--) begin
      entry.symbol     = CHAR_ZERO + CHAR_BITS'(digits[i]);
      entry.final_mark = (i == 0);
      expected_text.push_back(entry);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (start && !busy)
        queue_decimal_text(value, treat_as_signed);
      if (strobe) begin
        char_count++;
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("character %0d with no text pending: char %0d last %0b",
                                    char_count, character, last_char));
        end else begin
          want = expected_text.pop_front();
          if (character !== want.symbol)
            report_mismatch($sformatf("character %0d: char %0d, expected %0d",
                                      char_count, character, want.symbol));
          if (last_char !== want.final_mark)
            report_mismatch($sformatf("character %0d: last_char %0b, expected %0b",
                                      char_count, last_char, want.final_mark));
        end
      end
    end
    pending = expected_text.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the decimal ASCII formatter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import i2da_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [INPUT_BITS-1:0] value;
  logic                  treat_as_signed;
  logic                  strobe;
  logic [CHAR_BITS-1:0]  character;
  logic                  last_char;
  int                    errors;
  int                    pending;

  localparam int RANDOM_ITEMS = 200;

  integer_to_decimal_ascii u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .value           (value),
    .treat_as_signed (treat_as_signed),
    .strobe          (strobe),
    .character       (character),
    .last_char       (last_char)
  );

  decimal_text_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .value           (value),
    .treat_as_signed (treat_as_signed),
    .strobe          (strobe),
    .character       (character),
    .last_char       (last_char),
    .errors          (errors),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_item(input logic [INPUT_BITS-1:0] word, input logic as_signed);
    @(negedge clk);
    start           = 1'b1;
    value           = word;
    treat_as_signed = as_signed;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic sender_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 4);
    @(negedge clk);
    start = 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  task automatic drain_text();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [INPUT_BITS-1:0] random_word();
    logic [INPUT_BITS-1:0] raw;
    logic [INPUT_BITS-1:0] ten_power;
    int                    pick;
    raw  = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      return raw;
    end else if (pick < 6) begin
      return raw >> $urandom_range(1, 63);
    end else if (pick < 8) begin
      ten_power = 1;
      repeat ($urandom_range(0, 19)) ten_power = ten_power * 10;
      return ten_power + INPUT_BITS'($urandom_range(0, 2)) - 1;
    end else begin
      return -(raw >> $urandom_range(1, 63));
    end
  endfunction

  initial begin
    logic [INPUT_BITS-1:0] directed_words[$];
    bit                    no_idle;
    rst             = 1'b1;
    start           = 1'b0;
    value           = '0;
    treat_as_signed = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_words = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
                       64'd999_999_999_999_999_999, 64'd1_000_000_000_000_000_000,
                       64'd9_999_999_999_999_999_999, 64'd10_000_000_000_000_000_000,
                       64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                       64'hFFFF_FFFF_FFFF_FFFF, -64'd10};
    foreach (directed_words[i]) begin
      send_item(directed_words[i], 1'b0);
      send_item(directed_words[i], 1'b1);
      if (i % 4 == 3) sender_gap();
    end
    drain_text();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 100 && n < 160);
      send_item(random_word(), 1'($urandom_range(0, 1)));
      if (n == 60 || n == 180) drain_text();
      else if (!no_idle && $urandom_range(0, 99) < 29) sender_gap();
    end
    drain_text();
    repeat (120) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
